>>> rtl/aco_pu_pkg.sv
// Shared types and constants for the pheromone update block.
package aco_pu_pkg;

    localparam int CITIES_DEF = 64;

    localparam logic [15:0] RHO_RST = 16'd32768;
    localparam logic [15:0] DEPOSIT_RST = 16'd100;
    localparam logic [31:0] INIT_LEVEL_RST = 32'd262144;
    localparam logic [31:0] MAX_LEVEL = 32'hFFFF_FFFF;

    localparam int DIV_STEPS = 32;

    localparam logic [1:0] MODE_DEPOSIT = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_RESTORE = 2'd2;

    localparam logic [1:0] REG_RHO = 2'd0;
    localparam logic [1:0] REG_DEPOSIT = 2'd1;
    localparam logic [1:0] REG_INIT_LEVEL = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  row_city;
        logic [5:0]  col_city;
        logic [23:0] tour_length;
        logic        round_end;
    } item_t;

    typedef struct packed {
        logic [31:0] level;
        logic        saturated;
    } result_t;

    typedef struct packed {
        logic        lvl_we;
        logic        pnd_we;
        logic [31:0] lvl_data;
        logic [31:0] pnd_data;
    } store_wr_t;

endpackage

>>> rtl/aco_pu_div.sv
// Bit-serial divider for the deposit amount (numerator << 32) / tour length.
module aco_pu_div
    import aco_pu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] numer,
    input  logic [23:0] denom,
    output logic        done,
    output logic [31:0] quotient,
    output logic        saturated
);

    localparam int SW = $clog2(DIV_STEPS + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [24:0]   rem_reg, rem_next;
    logic [31:0]   q_reg, q_next;
    logic          sat_reg, sat_next;
    logic [23:0]   den_reg, den_next;
    logic [24:0]   rem_sh;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        den_next  = den_reg;
        rem_sh    = {rem_reg[23:0], 1'b0};
        if (start)
        begin
            den_next = denom;
            if ({8'd0, numer} >= denom)
            begin
                q_next    = MAX_LEVEL;
                sat_next  = 1'b1;
                done_next = 1'b1;
                run_next  = 1'b0;
            end
            else
            begin
                rem_next = {9'd0, numer};
                q_next   = '0;
                sat_next = 1'b0;
                cnt_next = SW'(DIV_STEPS);
                run_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - SW'(1);
            if (cnt_reg == SW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign saturated = sat_reg;

endmodule

>>> rtl/aco_pu_store.sv
// Level and pending-deposit memories, one shared address, registered reads.
module aco_pu_store
    import aco_pu_pkg::*;
#(
    parameter int CITIES = CITIES_DEF
)
(
    input  logic                                clk,
    input  logic [$clog2(CITIES*CITIES)-1:0]    addr,
    input  store_wr_t                           wr,
    output logic [31:0]                         lvl_rd,
    output logic [31:0]                         pnd_rd
);

    localparam int CELLS = CITIES * CITIES;

    logic [31:0] lvl_mem [CELLS];
    logic [31:0] pnd_mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (wr.lvl_we)
        begin
            lvl_mem[addr] <= wr.lvl_data;
        end
        lvl_rd <= lvl_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.pnd_we)
        begin
            pnd_mem[addr] <= wr.pnd_data;
        end
        pnd_rd <= pnd_mem[addr];
    end

endmodule

>>> rtl/aco_pheromone_update_top.sv
// Top level of the pheromone update block: sequencer, sweep datapath, config registers.
// Usage: an item (cmd) transfers on a clock edge with start high and busy low.
// Exactly one result per item appears on result for one cycle with done high;
// the receiver must take it then, it cannot stall the block.
// Config: cfg_valid/cfg_ready with cfg_index (0 rho, 1 deposit constant,
// 2 initial level) and cfg_data; cfg_ready is always high. Write only while idle.
// Steps per item, from transfer to done, all ending in the result read:
//   read: the result read alone (address, wait state, output).
//   deposit: if both cities lie in the matrix, the bit-serial divider (one
//     quotient bit per cycle, skipped when the quotient clamps), then a read,
//     a wait and a write per touched entry, two entries for two different cities.
//   deposit with round end: add a sweep of one read, two passes of the shared
//     multiplier and one write per matrix entry (CITIES*CITIES entries).
//   restore: CITIES*CITIES entries, one entry written per cycle.
// busy stays high through the result cycle; one item is in work at a time.
// After reset the block sets every level to INIT_LEVEL_RST and every pending deposit
// to zero, one entry per cycle, with busy high; config writes are taken meanwhile.
module aco_pheromone_update_top
    import aco_pu_pkg::*;
#(
    parameter int CITIES = CITIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       cmd,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CELLS = CITIES * CITIES;
    localparam int AW = $clog2(CELLS);
    localparam int CW = $clog2(CITIES);
    localparam logic [8:0] CITIES_W = 9'(CITIES);

    typedef enum logic [14:0] {
        S_CLEAR    = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_DIV      = 15'b000000000000100,
        S_DEP_RD   = 15'b000000000001000,
        S_DEP_WAIT = 15'b000000000010000,
        S_DEP_WR   = 15'b000000000100000,
        S_SW_RD    = 15'b000000001000000,
        S_SW_M1    = 15'b000000010000000,
        S_SW_M2    = 15'b000000100000000,
        S_SW_M3    = 15'b000001000000000,
        S_SW_WR    = 15'b000010000000000,
        S_RST      = 15'b000100000000000,
        S_RES_RD   = 15'b001000000000000,
        S_RES_WAIT = 15'b010000000000000,
        S_RES_OUT  = 15'b100000000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    item_t         item_reg, item_next;
    logic          inside_reg, inside_next;
    logic          side_reg, side_next;
    logic          sat_reg, sat_next;
    logic [15:0]   rho_reg;
    logic [15:0]   dep_reg;
    logic [31:0]   init_reg;
    logic [31:0]   p1_reg, p1_next;
    logic [31:0]   lv_reg, lv_next;
    logic [31:0]   pnd_reg, pnd_next;
    logic [32:0]   t_reg, t_next;
    logic          diag_reg, diag_next;

    logic          div_start;
    logic          div_done;
    logic [31:0]   div_q;
    logic          div_sat;
    store_wr_t     wr;
    logic [31:0]   lvl_rd;
    logic [31:0]   pnd_rd;

    logic [16:0]   keep;
    logic [32:0]   mul_a;
    logic [16:0]   mul_b;
    logic [49:0]   mul;
    logic [32:0]   dep_sum;
    logic          cmd_inside;
    logic          addr_last;
    logic [AW-1:0] idx_rc;
    logic [AW-1:0] idx_cr;

    aco_pu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numer     (dep_reg),
        .denom     (cmd.tour_length),
        .done      (div_done),
        .quotient  (div_q),
        .saturated (div_sat)
    );

    aco_pu_store #(
        .CITIES (CITIES)
    ) u_store (
        .clk    (clk),
        .addr   (addr_reg),
        .wr     (wr),
        .lvl_rd (lvl_rd),
        .pnd_rd (pnd_rd)
    );

    assign keep       = 17'd65536 - {1'b0, rho_reg};
    assign mul_a      = (state_reg == S_SW_WR) ? t_reg : {1'b0, lv_reg};
    assign mul_b      = (state_reg == S_SW_WR) ? {1'b0, rho_reg} : keep;
    assign mul        = 50'(mul_a) * 50'(mul_b);
    assign dep_sum    = {1'b0, pnd_rd} + {1'b0, div_q};
    assign cmd_inside = ({3'd0, cmd.row_city} < CITIES_W) && ({3'd0, cmd.col_city} < CITIES_W);
    assign addr_last  = (addr_reg == AW'(CELLS - 1));
    assign idx_rc     = AW'(AW'(item_reg.row_city) * AW'(CITIES) + AW'(item_reg.col_city));
    assign idx_cr     = AW'(AW'(item_reg.col_city) * AW'(CITIES) + AW'(item_reg.row_city));

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        item_next   = item_reg;
        inside_next = inside_reg;
        side_next   = side_reg;
        sat_next    = sat_reg;
        p1_next     = p1_reg;
        lv_next     = lv_reg;
        pnd_next    = pnd_reg;
        t_next      = t_reg;
        diag_next   = diag_reg;
        div_start   = 1'b0;
        wr          = '0;
        case (state_reg)
            S_CLEAR:
            begin
                wr.lvl_we   = 1'b1;
                wr.lvl_data = INIT_LEVEL_RST;
                wr.pnd_we   = 1'b1;
                wr.pnd_data = '0;
                addr_next   = addr_reg + AW'(1);
                if (addr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next   = cmd;
                    inside_next = cmd_inside;
                    side_next   = 1'b0;
                    sat_next    = 1'b0;
                    addr_next   = '0;
                    r_next      = '0;
                    c_next      = '0;
                    case (cmd.mode)
                        MODE_DEPOSIT:
                        begin
                            if (cmd_inside)
                            begin
                                state_next = S_DIV;
                            end
                            else if (cmd.round_end)
                            begin
                                state_next = S_SW_RD;
                            end
                            else
                            begin
                                state_next = S_RES_RD;
                            end
                        end
                        MODE_RESTORE:
                        begin
                            state_next = S_RST;
                        end
                        default:
                        begin
                            state_next = S_RES_RD;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    sat_next   = sat_reg | div_sat;
                    state_next = S_DEP_RD;
                end
            end
            S_DEP_RD:
            begin
                addr_next  = side_reg ? idx_cr : idx_rc;
                state_next = S_DEP_WAIT;
            end
            S_DEP_WAIT:
            begin
                state_next = S_DEP_WR;
            end
            S_DEP_WR:
            begin
                wr.pnd_we   = 1'b1;
                wr.pnd_data = dep_sum[32] ? MAX_LEVEL : dep_sum[31:0];
                sat_next    = sat_reg | dep_sum[32];
                if (!side_reg && (item_reg.row_city != item_reg.col_city))
                begin
                    side_next  = 1'b1;
                    state_next = S_DEP_RD;
                end
                else if (item_reg.round_end)
                begin
                    addr_next  = '0;
                    r_next     = '0;
                    c_next     = '0;
                    state_next = S_SW_RD;
                end
                else
                begin
                    state_next = S_RES_RD;
                end
            end
            S_SW_RD:
            begin
                state_next = S_SW_M1;
            end
            S_SW_M1:
            begin
                lv_next    = lvl_rd;
                pnd_next   = pnd_rd;
                diag_next  = (r_reg == c_reg);
                state_next = S_SW_M2;
            end
            S_SW_M2:
            begin
                p1_next    = mul[47:16];
                state_next = S_SW_M3;
            end
            S_SW_M3:
            begin
                t_next     = diag_reg ? {1'b0, lv_reg} : ({1'b0, p1_reg} + {1'b0, pnd_reg});
                state_next = S_SW_WR;
            end
            S_SW_WR:
            begin
                wr.pnd_we   = 1'b1;
                wr.pnd_data = '0;
                wr.lvl_we   = 1'b1;
                wr.lvl_data = (mul[49:48] != 2'b00) ? MAX_LEVEL : mul[47:16];
                sat_next    = sat_reg | (mul[49:48] != 2'b00);
                if (addr_last)
                begin
                    state_next = S_RES_RD;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                    if (c_reg == CW'(CITIES - 1))
                    begin
                        c_next = '0;
                        r_next = r_reg + CW'(1);
                    end
                    else
                    begin
                        c_next = c_reg + CW'(1);
                    end
                    state_next = S_SW_RD;
                end
            end
            S_RST:
            begin
                wr.lvl_we   = 1'b1;
                wr.lvl_data = init_reg;
                addr_next   = addr_reg + AW'(1);
                if (addr_last)
                begin
                    state_next = S_RES_RD;
                end
            end
            S_RES_RD:
            begin
                addr_next  = idx_rc;
                state_next = S_RES_WAIT;
            end
            S_RES_WAIT:
            begin
                state_next = S_RES_OUT;
            end
            S_RES_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if ((state_reg == S_IDLE) && start && (cmd.mode == MODE_DEPOSIT) && cmd_inside)
        begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            side_reg  <= 1'b0;
            sat_reg   <= 1'b0;
            rho_reg   <= RHO_RST;
            dep_reg   <= DEPOSIT_RST;
            init_reg  <= INIT_LEVEL_RST;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            side_reg  <= side_next;
            sat_reg   <= sat_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RHO:        rho_reg  <= cfg_data[15:0];
                    REG_DEPOSIT:    dep_reg  <= cfg_data[15:0];
                    REG_INIT_LEVEL: init_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        inside_reg <= inside_next;
        p1_reg     <= p1_next;
        lv_reg     <= lv_next;
        pnd_reg    <= pnd_next;
        t_reg      <= t_next;
        diag_reg   <= diag_next;
    end

    assign busy             = (state_reg != S_IDLE);
    assign cfg_ready        = 1'b1;
    assign done             = (state_reg == S_RES_OUT);
    assign result.level     = inside_reg ? lvl_rd : '0;
    assign result.saturated = sat_reg;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block not idle after result");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside division step");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not start work");

endmodule
